// ===== sv/frs_pkg.sv =====
// Package for the FPU register stack: request and response transaction types,
// request codes, and the tag and status word constants.
// No dependencies.
`timescale 1ns / 1ps

package frs_pkg;

	localparam int unsigned NumSlots  = 8;
	localparam int unsigned SlotW     = $clog2(NumSlots);
	localparam int unsigned DataW     = 64;
	localparam int unsigned WordW     = 16;

	localparam logic [WordW-1:0] TagAllEmpty = 16'hFFFF;
	localparam logic [WordW-1:0] TopClear    = 16'hC7FF;
	localparam logic [1:0]       TagFull     = 2'b00;
	localparam logic [1:0]       TagEmpty    = 2'b11;

	// Request codes.
	typedef enum logic [2:0] {
		REQ_PUSH   = 3'd0,
		REQ_POP    = 3'd1,
		REQ_READ   = 3'd2,
		REQ_WRITE  = 3'd3,
		REQ_QUERY  = 3'd4,
		REQ_COND   = 3'd5,
		REQ_SYNC   = 3'd6,
		REQ_REINIT = 3'd7
	} req_code_t;

	// Condition bit selectors.
	typedef enum logic [1:0] {
		COND_C0 = 2'd0,
		COND_C1 = 2'd1,
		COND_C2 = 2'd2,
		COND_C3 = 2'd3
	} cond_sel_t;

	typedef struct packed {
		logic [2:0]       req_type;
		logic [SlotW-1:0] rel_index;
		logic [DataW-1:0] data_value;
		logic [1:0]       cond_select;
		logic             cond_value;
	} req_t;

	typedef struct packed {
		logic [DataW-1:0] read_data;
		logic             slot_empty;
		logic [WordW-1:0] status_out;
		logic [WordW-1:0] tag_out;
		logic [SlotW-1:0] top_out;
	} rsp_t;

	// Status word mask of one condition bit.
	function automatic logic [WordW-1:0] cond_mask(input logic [1:0] sel);
		logic [WordW-1:0] m;
		case (cond_sel_t'(sel))
			COND_C0: m = 16'h0100;
			COND_C1: m = 16'h0200;
			COND_C2: m = 16'h0400;
			COND_C3: m = 16'h4000;
			default: m = '0;
		endcase
		return m;
	endfunction

endpackage

// ===== sv/fpu_register_stack.sv =====
// Responses are registered in the response register, fed via the skid stage when stalled.
// Throughput: one transaction per cycle while req_stall is low.
// A one-entry skid stage before the response register takes a request while it stalls.
// Reset (arst_n low): all slots zero, tag word all empty, top and status zero,
// no response pending. A reinitialize request returns slots, tag, top and status to it.
// Top level of the FPU register stack; depends on frs_pkg.
`timescale 1ns / 1ps

module fpu_register_stack (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  frs_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output frs_pkg::rsp_t rsp
);
	import frs_pkg::*;

	logic [DataW-1:0] stack_q [NumSlots];
	logic [WordW-1:0] tag_q;
	logic [WordW-1:0] status_q;
	logic [SlotW-1:0] top_q;

	logic [WordW-1:0] tag_n;
	logic [WordW-1:0] status_n;
	logic [SlotW-1:0] top_n;
	logic             wr_en;
	logic [SlotW-1:0] wr_slot;
	logic             clr_all;
	logic [SlotW-1:0] rel_slot;
	rsp_t             result;

	rsp_t rsp_q;
	logic rsp_valid_q;
	rsp_t skid_q;
	logic skid_valid_q;
	logic accept;

	assign accept    = req_valid && !req_stall;
	assign req_stall = skid_valid_q;
	assign rel_slot  = top_q + req.rel_index;

	// Next state and result for the request at the input.
	always_comb begin
		tag_n    = tag_q;
		status_n = status_q;
		top_n    = top_q;
		wr_en    = 1'b0;
		wr_slot  = rel_slot;
		clr_all  = 1'b0;
		result.read_data  = '0;
		result.slot_empty = 1'b0;
		case (req_code_t'(req.req_type))
			REQ_PUSH: begin
				top_n = top_q - 1'b1;
				tag_n[{top_n, 1'b0} +: 2] = TagFull;
				wr_en   = 1'b1;
				wr_slot = top_n;
			end
			REQ_POP: begin
				tag_n[{top_q, 1'b0} +: 2] = TagEmpty;
				top_n = top_q + 1'b1;
			end
			REQ_READ: begin
				result.read_data = stack_q[rel_slot];
			end
			REQ_WRITE: begin
				wr_en = 1'b1;
				tag_n[{rel_slot, 1'b0} +: 2] = TagFull;
			end
			REQ_QUERY: begin
				result.slot_empty = (tag_q[{rel_slot, 1'b0} +: 2] == TagEmpty);
			end
			REQ_COND: begin
				status_n = (status_q & ~cond_mask(req.cond_select))
					| (req.cond_value ? cond_mask(req.cond_select) : '0);
			end
			REQ_SYNC: begin
				status_n = status_q & TopClear;
				status_n[13:11] = top_q;
			end
			default: begin
				clr_all  = 1'b1;
				tag_n    = TagAllEmpty;
				status_n = '0;
				top_n    = '0;
			end
		endcase
		result.status_out = status_n;
		result.tag_out    = tag_n;
		result.top_out    = top_n;
	end

	// Architectural state update on an accepted transaction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_q    <= TagAllEmpty;
			status_q <= '0;
			top_q    <= '0;
			for (int i = 0; i < NumSlots; i++) begin
				stack_q[i] <= '0;
			end
		end else if (accept) begin
			tag_q    <= tag_n;
			status_q <= status_n;
			top_q    <= top_n;
			for (int i = 0; i < NumSlots; i++) begin
				if (clr_all) begin
					stack_q[i] <= '0;
				end else if (wr_en && wr_slot == SlotW'(i)) begin
					stack_q[i] <= req.data_value;
				end
			end
		end
	end

	// Response register with a one-entry skid stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!rsp_valid_q || !rsp_stall) begin
			rsp_valid_q  <= skid_valid_q || accept;
			skid_valid_q <= 1'b0;
		end else if (accept) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!rsp_valid_q || !rsp_stall) begin
			rsp_q <= skid_valid_q ? skid_q : result;
		end else if (accept) begin
			skid_q <= result;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// ===== sv/frs_checker.sv =====
// Port-level checks for the FPU register stack, bound to the top level.
// Depends on frs_pkg and fpu_register_stack.
`timescale 1ns / 1ps

module frs_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          req_valid,
	input logic          req_stall,
	input frs_pkg::req_t req,
	input logic          rsp_valid,
	input logic          rsp_stall,
	input frs_pkg::rsp_t rsp
);
	import frs_pkg::*;

	// No response is offered while reset is applied.
	a_reset_idle: assert property (@(posedge clk) !arst_n |-> !rsp_valid)
		else $error("response valid during reset");

	// A stalled response transaction holds its value.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("stalled response changed");

	// Requests are only held off while a response is pending.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> rsp_valid)
		else $error("request stalled with no pending response");

	// A reinitialize into an empty output shows the reset state next cycle.
	a_reinit: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall && !rsp_valid && req.req_type == REQ_REINIT
		|=> rsp_valid && rsp.tag_out == TagAllEmpty && rsp.status_out == '0
			&& rsp.top_out == '0 && rsp.read_data == '0)
		else $error("reinitialize did not report reset state");

	// A push into an empty output leaves the new top slot tagged full.
	a_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall && !rsp_valid && req.req_type == REQ_PUSH
		|=> rsp_valid && ((rsp.tag_out >> {rsp.top_out, 1'b0}) & 16'h0003) == '0)
		else $error("pushed slot not tagged full");

endmodule

bind fpu_register_stack frs_checker u_frs_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.req       (req),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);
